@@ hdl/pfla_pkg.sv @@
`timescale 1ns / 1ps
package pfla_pkg;

	localparam int PAGE_W  = 12;
	localparam int TOTAL_W = 13;
	localparam int PAGE_SPAN = 4096;

	typedef enum logic [0:0] {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [0:0] {
		REG_PAGE_LIMIT      = 1'b0,
		REG_FIRST_FREE_PAGE = 1'b1
	} reg_idx_t;

	localparam logic [1:0] ST_ALLOCATED = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_FREED     = 2'd2;

	typedef struct packed {
		logic exec;
		logic load;
	} pfla_cmd_t;

	typedef struct packed {
		logic pop;
	} pfla_stat_t;

endpackage

@@ hdl/pfla_ctrl.sv @@
`timescale 1ns / 1ps
module pfla_ctrl import pfla_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  pfla_stat_t stat,
	output pfla_cmd_t  cmd,
	output logic       busy
);

	typedef enum logic [1:0] {
		S_IDLE  = 2'b01,
		S_FETCH = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign accept   = start && (state_q == S_IDLE);
	assign cmd.exec = accept;
	assign cmd.load = (state_q == S_FETCH);
	assign busy     = (state_q == S_FETCH);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && stat.pop) state_d = S_FETCH;
			end
			S_FETCH: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_fetch_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FETCH) |-> $past(accept && stat.pop))
		else $error("fetch state without a pop");

endmodule

@@ hdl/pfla_datapath.sv @@
`timescale 1ns / 1ps
module pfla_datapath import pfla_pkg::*; #(
	parameter int MAX_PAGES = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pfla_cmd_t          cmd,
	output pfla_stat_t         stat,
	input  logic               op,
	input  logic [PAGE_W-1:0]  page,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [TOTAL_W-1:0] cfg_data,
	output logic               done,
	output logic [PAGE_W-1:0]  granted_page,
	output logic [1:0]         status
);

	localparam int DEPTH = (MAX_PAGES < PAGE_SPAN) ? MAX_PAGES : PAGE_SPAN;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [TOTAL_W-1:0] CAP = TOTAL_W'(DEPTH);

	logic [PAGE_W-1:0]  mem [DEPTH];

	logic [TOTAL_W-1:0] total_q;
	logic [TOTAL_W-1:0] wm_q;
	logic [PAGE_W-1:0]  head_q;
	logic [PAGE_W-1:0]  link_q;
	logic [PAGE_W-1:0]  rd_q;
	logic               done_q;
	logic [PAGE_W-1:0]  granted_q;
	logic [1:0]         status_q;

	logic [TOTAL_W-1:0] bound;
	logic               list_empty;
	logic               full;
	logic               page_ok;
	logic               is_free;

	assign bound      = (total_q < CAP) ? total_q : CAP;
	assign list_empty = (head_q == '0);
	assign full       = (wm_q >= bound);
	assign page_ok    = (32'(page) < 32'(MAX_PAGES));
	assign is_free    = (op_t'(op) == OP_FREE);
	assign stat.pop   = !is_free && !list_empty;

	assign done         = done_q;
	assign granted_page = granted_q;
	assign status       = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= TOTAL_W'(PAGE_SPAN);
			wm_q    <= TOTAL_W'(1);
			head_q  <= '0;
			link_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.exec;
			if (cfg_we) begin
				if (reg_idx_t'(cfg_index) == REG_PAGE_LIMIT) begin
					total_q <= cfg_data;
				end else begin
					wm_q <= {1'b0, cfg_data[PAGE_W-1:0]};
				end
			end
			if (cmd.exec) begin
				if (is_free) begin
					if (page_ok) begin
						link_q <= head_q;
						head_q <= page;
					end
				end else if (!list_empty) begin
					head_q <= link_q;
				end else if (!full) begin
					wm_q <= wm_q + TOTAL_W'(1);
				end
			end
			if (cmd.load) link_q <= rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (is_free) begin
				granted_q <= '0;
				status_q  <= ST_FREED;
			end else if (!list_empty) begin
				granted_q <= head_q;
				status_q  <= ST_ALLOCATED;
			end else if (!full) begin
				granted_q <= wm_q[PAGE_W-1:0];
				status_q  <= ST_ALLOCATED;
			end else begin
				granted_q <= '0;
				status_q  <= ST_FULL;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && is_free && page_ok) mem[page[AW-1:0]] <= head_q;
		if (cmd.exec && stat.pop) rd_q <= mem[link_q[AW-1:0]];
	end

	a_done_follows_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done_q == $past(cmd.exec))
		else $error("result beat not one cycle after accept");

	a_zero_unless_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && (status_q != ST_ALLOCATED) |-> (granted_q == '0))
		else $error("nonzero page on full or free");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (status_q == ST_ALLOCATED || status_q == ST_FULL || status_q == ST_FREED))
		else $error("bad status code");

	a_no_load_with_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !cmd.exec)
		else $error("link fetch overlaps an accept");

endmodule

@@ hdl/page_free_list_allocator.sv @@
`timescale 1ns / 1ps
// Page allocator: linked free list over a next-link memory, backed by a
// bump watermark for pages never handed out.
// Request channel: start with op and page; a beat is taken at a clock edge
// where start is high and busy is low. op 0 allocates, op 1 frees page.
// Result channel: done is high for one cycle with granted_page and status,
// the cycle after the request beat. The receiver cannot stall it.
// A free, an allocate from the watermark and a full report leave busy low.
// An allocate that pops the list holds busy high for one cycle while the
// next link of the new head is read from the link memory.
// Config channel: cfg_valid/cfg_ready with cfg_index (0 page limit,
// 1 first_free_page) and cfg_data; cfg_ready is always high. Writing
// first_free_page loads the watermark. Write only while idle.
// Reset: list empty, watermark 1, page limit 4096. The link memory is not
// cleared; popping the last listed page may read an unwritten entry, unused.
module page_free_list_allocator import pfla_pkg::*; #(
	parameter int MAX_PAGES = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               op,
	input  logic [PAGE_W-1:0]  page,
	output logic               done,
	output logic [PAGE_W-1:0]  granted_page,
	output logic [1:0]         status,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [TOTAL_W-1:0] cfg_data
);

	pfla_cmd_t  cmd;
	pfla_stat_t stat;

	assign cfg_ready = 1'b1;

	pfla_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	pfla_datapath #(
		.MAX_PAGES (MAX_PAGES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.op           (op),
		.page         (page),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.done         (done),
		.granted_page (granted_page),
		.status       (status)
	);

endmodule
